// File: rtl/ipv6nc_pkg.sv
package ipv6nc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam int ADDR_W = 64;
  localparam int MAC_W = 48;
  localparam int TIME_W = 32;
  localparam int COUNT_OUT_W = 5;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(1000);

  typedef enum logic [1:0] {
    OP_LEARN  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_AGE    = 2'd2
  } opcode_t;

  // Packed so that the first field lands in the highest bits.
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [MAC_W-1:0]  mac_in;
    logic [ADDR_W-1:0] ip_low;
    logic [ADDR_W-1:0] ip_high;
  } req_data_t;

  typedef struct packed {
    opcode_t   opcode;
    req_data_t data;
  } req_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   table_full;
    logic [MAC_W-1:0]       mac_out;
    logic                   found;
  } res_t;

  localparam int IN_DATA_W = (($bits(req_data_t) + 7) / 8) * 8;
  localparam int RES_W = $bits(res_t);
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic [ADDR_W-1:0] key_high;
    logic [ADDR_W-1:0] key_low;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] seen_time;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

endpackage

// File: rtl/ipv6nc_table.sv
module ipv6nc_table (
  input  logic                       clk,
  input  ipv6nc_pkg::mem_rd_t        rd_req,
  output ipv6nc_pkg::entry_t         rd_data,
  input  ipv6nc_pkg::mem_wr_t        wr_req
);

  ipv6nc_pkg::entry_t mem [ipv6nc_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule

// File: rtl/ipv6nc_engine.sv
module ipv6nc_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  ipv6nc_pkg::req_t              req_in,
  input  logic [ipv6nc_pkg::TIME_W-1:0] timeout,
  output logic                          busy,
  input  logic                          res_ready,
  output logic                          res_valid,
  output ipv6nc_pkg::res_t              res,
  output ipv6nc_pkg::mem_rd_t           rd_req,
  input  ipv6nc_pkg::entry_t            rd_data,
  output ipv6nc_pkg::mem_wr_t           wr_req
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                               state;
  ipv6nc_pkg::req_t                     req;
  logic [ipv6nc_pkg::IDX_W-1:0]         scan_idx;
  logic                                 chk_en;
  logic [ipv6nc_pkg::IDX_W-1:0]         chk_idx;
  logic [ipv6nc_pkg::TABLE_ENTRIES-1:0] valid_bits;
  logic [ipv6nc_pkg::CNT_W-1:0]         count;
  logic [ipv6nc_pkg::CNT_W-1:0]         count_next;
  logic                                 match_found;
  logic [ipv6nc_pkg::IDX_W-1:0]         match_idx;
  logic [ipv6nc_pkg::MAC_W-1:0]         match_mac;
  logic                                 free_found;
  logic [ipv6nc_pkg::IDX_W-1:0]         free_idx;
  logic [ipv6nc_pkg::TIME_W-1:0]        age;
  logic                                 chk_live;
  logic                                 hit;
  logic                                 expired;
  logic                                 is_learn;
  logic                                 insert;
  logic                                 finish;

  assign chk_live = chk_en && valid_bits[chk_idx];
  assign hit = chk_live && (rd_data.key_high == req.data.ip_high)
               && (rd_data.key_low == req.data.ip_low);
  assign age = req.data.now - rd_data.seen_time;
  assign expired = chk_live && (req.opcode == ipv6nc_pkg::OP_AGE) && (age > timeout);
  assign is_learn = (req.opcode == ipv6nc_pkg::OP_LEARN);
  assign insert = is_learn && !match_found && free_found;
  assign finish = (state == ST_DONE) && res_ready;

  assign busy = (state != ST_IDLE);
  assign res_valid = finish;

  assign rd_req.en = (state == ST_SCAN);
  assign rd_req.addr = scan_idx;

  assign wr_req.en = finish && is_learn && (match_found || free_found);
  assign wr_req.addr = match_found ? match_idx : free_idx;
  assign wr_req.data.key_high = req.data.ip_high;
  assign wr_req.data.key_low = req.data.ip_low;
  assign wr_req.data.mac = req.data.mac_in;
  assign wr_req.data.seen_time = req.data.now;

  always_comb begin
    count_next = count;
    if (expired) begin
      count_next = count - ipv6nc_pkg::CNT_W'(1);
    end else if (finish && insert) begin
      count_next = count + ipv6nc_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    res.found = 1'b0;
    res.mac_out = '0;
    res.table_full = 1'b0;
    res.entry_count = ipv6nc_pkg::COUNT_OUT_W'(count_next);
    unique case (req.opcode)
      ipv6nc_pkg::OP_LEARN: begin
        res.found = match_found;
        res.table_full = !match_found && !free_found;
      end
      ipv6nc_pkg::OP_LOOKUP: begin
        res.found = match_found;
        res.mac_out = match_found ? match_mac : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chk_en <= 1'b0;
      valid_bits <= '0;
      count <= '0;
    end else begin
      chk_en <= (state == ST_SCAN);
      count <= count_next;
      if (expired) begin
        valid_bits[chk_idx] <= 1'b0;
      end
      if (finish && insert) begin
        valid_bits[free_idx] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx == ipv6nc_pkg::LAST_IDX) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= scan_idx;
    if (start && (state == ST_IDLE)) begin
      req <= req_in;
      scan_idx <= '0;
      match_found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (state == ST_SCAN) begin
        scan_idx <= scan_idx + ipv6nc_pkg::IDX_W'(1);
      end
      if (hit && !match_found) begin
        match_found <= 1'b1;
        match_idx <= chk_idx;
        match_mac <= rd_data.mac;
      end
      if (chk_en && !valid_bits[chk_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx <= chk_idx;
      end
    end
  end

endmodule

// File: rtl/ipv6_neighbor_cache_aging_unit.sv
// IPv6 neighbor cache with aging.
// Requests enter on the s_t* channel: tuser carries the opcode (learn, lookup,
// age sweep) and tdata carries the address halves, the MAC and the current time.
// Each request yields exactly one result on the m_t* channel with the found
// flag, the MAC, the table-full flag and the live entry count.
// The timeout register is written through cfg_valid and cfg_data (cfg_ready is
// always high); the user must write it only while no request is in flight, as
// the block itself does not enforce this.
// Every request walks the whole table through the single read port of the
// entry memory, one entry per cycle; no new request is accepted until the walk
// has finished and its result has been passed to the output register.
// A learn writes the memory at most once, at the end of its walk.
// Reset clears all valid bits and the count, restores the timeout to 1000 and
// drops any pending result; the memory itself is not cleared.
// When the receiver stalls, the result is held in the output register; one
// more request can be accepted and walked, and it then waits until the
// output register is free.
module ipv6_neighbor_cache_aging_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // ip_high, ip_low, mac_in, now
  input  logic [ipv6nc_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // found, mac_out, table_full, entry_count, zero padding
  output logic [ipv6nc_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ipv6nc_pkg::TIME_W-1:0]     cfg_data
);

  logic [ipv6nc_pkg::TIME_W-1:0] entry_timeout;
  ipv6nc_pkg::req_t              req_in;
  ipv6nc_pkg::res_t              res;
  ipv6nc_pkg::mem_rd_t           rd_req;
  ipv6nc_pkg::mem_wr_t           wr_req;
  ipv6nc_pkg::entry_t            rd_data;
  logic                          busy;
  logic                          res_valid;
  logic                          res_ready;
  logic                          start;

  assign cfg_ready = 1'b1;
  assign s_tready = !busy;
  assign start = s_tvalid && s_tready;
  assign res_ready = !m_tvalid || m_tready;

  assign req_in.opcode = ipv6nc_pkg::opcode_t'(s_tuser);
  assign req_in.data = s_tdata[$bits(ipv6nc_pkg::req_data_t)-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_timeout <= ipv6nc_pkg::TIMEOUT_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        entry_timeout <= cfg_data;
      end
      if (res_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= ipv6nc_pkg::OUT_DATA_W'(res);
    end
  end

  ipv6nc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_in    (req_in),
    .timeout   (entry_timeout),
    .busy      (busy),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .rd_req    (rd_req),
    .rd_data   (rd_data),
    .wr_req    (wr_req)
  );

  ipv6nc_table u_table (
    .clk     (clk),
    .rd_req  (rd_req),
    .rd_data (rd_data),
    .wr_req  (wr_req)
  );

endmodule

// File: rtl/ipv6nc_checker.sv
module ipv6nc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ipv6nc_pkg::OUT_DATA_W-1:0] m_tdata
);

  ipv6nc_pkg::res_t res;

  assign res = m_tdata[ipv6nc_pkg::RES_W-1:0];

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Each request is walked alone, so the input closes right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request accepted during a walk");

  // A learn cannot both hit and be dropped.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.found && res.table_full))
    else $error("found and table_full both set");

  // A MAC is only returned together with a hit.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.found |-> res.mac_out == '0)
    else $error("MAC returned without a hit");

  // Reset drops any pending result.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind ipv6_neighbor_cache_aging_unit ipv6nc_checker u_checker (.*);
